[rtl/jsud_pkg.sv]
// ----------------------------------------------------------------------------
// jsud_pkg
// Shared types and constants of the JSON string unescape decoder.
// ----------------------------------------------------------------------------
package jsud_pkg;

    // decoder phase
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_BODY      = 4'd1,
        PH_ESC       = 4'd2,
        PH_HEX_FIRST = 4'd3,
        PH_WANT_BS   = 4'd4,
        PH_WANT_U    = 4'd5,
        PH_HEX_LOW   = 4'd6
    } phase_t;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_UNTERMINATED = 4'd1;
    localparam logic [3:0] ST_CONTROL_CHAR = 4'd2;
    localparam logic [3:0] ST_OPEN_ESCAPE  = 4'd3;
    localparam logic [3:0] ST_BAD_ESCAPE   = 4'd4;
    localparam logic [3:0] ST_TRUNC_HEX    = 4'd5;
    localparam logic [3:0] ST_BAD_HEX      = 4'd6;
    localparam logic [3:0] ST_UNPAIRED_HI  = 4'd7;
    localparam logic [3:0] ST_BAD_LOW      = 4'd8;
    localparam logic [3:0] ST_UNPAIRED_LO  = 4'd9;

    // surrogate and utf-8 range limits
    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [20:0] UTF8_ONE_MAX  = 21'h80;
    localparam logic [20:0] UTF8_TWO_MAX  = 21'h800;
    localparam logic [20:0] UTF8_THREE_MAX = 21'h10000;
    localparam logic [7:0]  CTRL_LIMIT    = 8'h20;

    // most results caused by one input item
    localparam int MAX_RESULTS = 4;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [3:0] status;
    } result_t;

    // batch of results handed from the decoder to the output buffer
    typedef struct packed {
        logic                          load;
        logic [2:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
    } batch_t;

endpackage

[rtl/jsud_in_stage.sv]
// ----------------------------------------------------------------------------
// jsud_in_stage
// Input register: holds one text item until the decoder takes it.
// ----------------------------------------------------------------------------
module jsud_in_stage
    import jsud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       text_end,
    output logic       item_valid,
    output logic [7:0] item_byte,
    output logic       item_end,
    input  logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    // free when empty or being emptied this cycle
    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload captured on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            end_reg  <= text_end;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_end   = end_reg;

endmodule

[rtl/jsud_decode.sv]
// ----------------------------------------------------------------------------
// jsud_decode
// Decoder state and single-pass step logic: escapes, hex groups, surrogate
// pairing and utf-8 encoding of one item into a batch of results.
// ----------------------------------------------------------------------------
module jsud_decode
    import jsud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       item_end,
    output logic       item_take,
    input  logic       load_ok,
    output batch_t     batch
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    phase_t      phase_reg, phase_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [2:0]  hex_digits_reg, hex_digits_next;
    logic        bad_digit_reg, bad_digit_next;
    logic [9:0]  high_surr_reg, high_surr_next;

    logic        fin;
    logic [3:0]  fin_status;
    logic        emit;
    logic [20:0] cp;
    logic        pass;
    logic [7:0]  pass_byte;

    logic [3:0]  nib;
    logic        nib_ok;
    logic [15:0] v;
    logic [2:0]  digits;
    logic        bad;

    logic [2:0]  nres;
    result_t [MAX_RESULTS-1:0] res;

    // hex digit value
    always_comb
    begin
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (item_byte >= 8'h30 && item_byte <= 8'h39)
        begin
            nib = item_byte[3:0];
        end
        else if ((item_byte >= 8'h61 && item_byte <= 8'h66) ||
                 (item_byte >= 8'h41 && item_byte <= 8'h46))
        begin
            nib = item_byte[3:0] + 4'd9;
        end
        else
        begin
            nib_ok = 1'b0;
        end
    end

    assign v      = {hex_value_reg[11:0], nib};
    assign digits = hex_digits_reg + 3'd1;
    assign bad    = bad_digit_reg || !nib_ok;

    // step logic
    always_comb
    begin
        phase_next      = phase_reg;
        hex_value_next  = hex_value_reg;
        hex_digits_next = hex_digits_reg;
        bad_digit_next  = bad_digit_reg;
        high_surr_next  = high_surr_reg;
        fin        = 1'b0;
        fin_status = ST_OK;
        emit       = 1'b0;
        cp         = 21'd0;
        pass       = 1'b0;
        pass_byte  = 8'd0;

        case (phase_reg)
            PH_BODY:
            begin
                if (item_end)
                begin
                    fin = 1'b1;
                    fin_status = ST_UNTERMINATED;
                end
                else if (item_byte == CH_QUOTE)
                begin
                    fin = 1'b1;
                    fin_status = ST_OK;
                end
                else if (item_byte < CTRL_LIMIT)
                begin
                    fin = 1'b1;
                    fin_status = ST_CONTROL_CHAR;
                end
                else if (item_byte == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    pass = 1'b1;
                    pass_byte = item_byte;
                end
            end
            PH_ESC:
            begin
                if (item_end)
                begin
                    fin = 1'b1;
                    fin_status = ST_OPEN_ESCAPE;
                end
                else
                begin
                    phase_next = PH_BODY;
                    case (item_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH:
                        begin
                            pass = 1'b1;
                            pass_byte = item_byte;
                        end
                        CH_B:
                        begin
                            pass = 1'b1;
                            pass_byte = 8'h08;
                        end
                        CH_F:
                        begin
                            pass = 1'b1;
                            pass_byte = 8'h0C;
                        end
                        CH_N:
                        begin
                            pass = 1'b1;
                            pass_byte = 8'h0A;
                        end
                        CH_R:
                        begin
                            pass = 1'b1;
                            pass_byte = 8'h0D;
                        end
                        CH_T:
                        begin
                            pass = 1'b1;
                            pass_byte = 8'h09;
                        end
                        CH_U:
                        begin
                            phase_next      = PH_HEX_FIRST;
                            hex_value_next  = 16'd0;
                            hex_digits_next = 3'd0;
                            bad_digit_next  = 1'b0;
                        end
                        default:
                        begin
                            fin = 1'b1;
                            fin_status = ST_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            PH_HEX_FIRST, PH_HEX_LOW:
            begin
                if (item_end)
                begin
                    fin = 1'b1;
                    fin_status = ST_TRUNC_HEX;
                end
                else if (digits < 3'd4)
                begin
                    hex_value_next  = v;
                    hex_digits_next = digits;
                    bad_digit_next  = bad;
                end
                else if (bad)
                begin
                    fin = 1'b1;
                    fin_status = ST_BAD_HEX;
                end
                else
                begin
                    hex_value_next  = 16'd0;
                    hex_digits_next = 3'd0;
                    bad_digit_next  = 1'b0;
                    if (phase_reg == PH_HEX_FIRST)
                    begin
                        if (v >= SURR_HI_FIRST && v <= SURR_HI_LAST)
                        begin
                            high_surr_next = v[9:0];
                            phase_next = PH_WANT_BS;
                        end
                        else if (v >= SURR_LO_FIRST && v <= SURR_LO_LAST)
                        begin
                            fin = 1'b1;
                            fin_status = ST_UNPAIRED_LO;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                            emit = 1'b1;
                            cp = {5'd0, v};
                        end
                    end
                    else if (v < SURR_LO_FIRST || v > SURR_LO_LAST)
                    begin
                        fin = 1'b1;
                        fin_status = ST_BAD_LOW;
                    end
                    else
                    begin
                        high_surr_next = 10'd0;
                        phase_next = PH_BODY;
                        emit = 1'b1;
                        cp = SUPP_BASE + {1'b0, high_surr_reg, v[9:0]};
                    end
                end
            end
            PH_WANT_BS:
            begin
                if (item_end || item_byte != CH_BSLASH)
                begin
                    fin = 1'b1;
                    fin_status = ST_UNPAIRED_HI;
                end
                else
                begin
                    phase_next = PH_WANT_U;
                end
            end
            PH_WANT_U:
            begin
                if (item_end || item_byte != CH_U)
                begin
                    fin = 1'b1;
                    fin_status = ST_UNPAIRED_HI;
                end
                else
                begin
                    phase_next      = PH_HEX_LOW;
                    hex_value_next  = 16'd0;
                    hex_digits_next = 3'd0;
                    bad_digit_next  = 1'b0;
                end
            end
            default:
            begin
                // idle: first byte is the opening quote, end of text ignored
                if (item_end)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next      = PH_BODY;
                    hex_value_next  = 16'd0;
                    hex_digits_next = 3'd0;
                    bad_digit_next  = 1'b0;
                    high_surr_next  = 10'd0;
                end
            end
        endcase

        // string end or error returns to idle
        if (fin)
        begin
            phase_next      = PH_IDLE;
            hex_value_next  = 16'd0;
            hex_digits_next = 3'd0;
            bad_digit_next  = 1'b0;
            high_surr_next  = 10'd0;
        end
    end

    // result batch
    always_comb
    begin
        nres = 3'd0;
        res  = '0;
        if (fin)
        begin
            nres = 3'd1;
            res[0].string_done = 1'b1;
            res[0].status = fin_status;
        end
        else if (pass)
        begin
            nres = 3'd1;
            res[0].out_byte = pass_byte;
            res[0].byte_valid = 1'b1;
        end
        else if (emit)
        begin
            res[0].byte_valid = 1'b1;
            res[1].byte_valid = 1'b1;
            res[2].byte_valid = 1'b1;
            res[3].byte_valid = 1'b1;
            if (cp < UTF8_ONE_MAX)
            begin
                nres = 3'd1;
                res[0].out_byte = {1'b0, cp[6:0]};
            end
            else if (cp < UTF8_TWO_MAX)
            begin
                nres = 3'd2;
                res[0].out_byte = {3'b110, cp[10:6]};
                res[1].out_byte = {2'b10, cp[5:0]};
            end
            else if (cp < UTF8_THREE_MAX)
            begin
                nres = 3'd3;
                res[0].out_byte = {4'b1110, cp[15:12]};
                res[1].out_byte = {2'b10, cp[11:6]};
                res[2].out_byte = {2'b10, cp[5:0]};
            end
            else
            begin
                nres = 3'd4;
                res[0].out_byte = {5'b11110, cp[20:18]};
                res[1].out_byte = {2'b10, cp[17:12]};
                res[2].out_byte = {2'b10, cp[11:6]};
                res[3].out_byte = {2'b10, cp[5:0]};
            end
        end
    end

    // an item with no results never waits on the output buffer
    assign item_take   = item_valid && ((nres == 3'd0) || load_ok);
    assign batch.load  = item_take && (nres != 3'd0);
    assign batch.count = nres;
    assign batch.res   = res;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hex_value_reg  <= 16'd0;
            hex_digits_reg <= 3'd0;
            bad_digit_reg  <= 1'b0;
            high_surr_reg  <= 10'd0;
        end
        else if (item_take)
        begin
            phase_reg      <= phase_next;
            hex_value_reg  <= hex_value_next;
            hex_digits_reg <= hex_digits_next;
            bad_digit_reg  <= bad_digit_next;
            high_surr_reg  <= high_surr_next;
        end
    end

endmodule

[rtl/jsud_out_buffer.sv]
// ----------------------------------------------------------------------------
// jsud_out_buffer
// Result register: holds one batch of up to four results and hands them out
// one transfer at a time.
// ----------------------------------------------------------------------------
module jsud_out_buffer
    import jsud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  batch_t     batch,
    output logic       load_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_done,
    output logic [3:0] status
);

    result_t [MAX_RESULTS-1:0] res_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_xfer;
    result_t    cur;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_xfer  = out_valid && out_ready;
    // a new batch may enter as the last result leaves
    assign load_ok   = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_ready);

    // count and read pointer
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (batch.load)
        begin
            cnt_next = batch.count;
            idx_next = 2'd0;
        end
        else if (out_xfer)
        begin
            cnt_next = cnt_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // batch payload
    always_ff @(posedge clk)
    begin
        if (batch.load)
        begin
            res_reg <= batch.res;
        end
    end

    assign cur         = res_reg[idx_reg];
    assign out_byte    = cur.out_byte;
    assign byte_valid  = cur.byte_valid;
    assign string_done = cur.string_done;
    assign status      = cur.status;

endmodule

[rtl/json_string_unescape_decoder_unit.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_decoder_unit
// Streaming JSON string literal decoder with utf-8 output.
// ----------------------------------------------------------------------------
// The unit takes one text byte (or an end-of-text mark) per cycle while the
// result register can take the item's results, and decodes JSON string
// literals into utf-8 bytes. While idle, the first byte counts as the opening
// quote. Plain bytes and simple escapes give one result; a \u escape gives one
// to four results once its last hex digit arrives; the closing quote, end of
// text or an error gives one final result with string_done set and a status
// code. Items that give no result (a backslash, hex digits before the last one)
// never wait on the result register. An item that gives n results occupies the
// output for n transfers, as the four-entry result register drains one result
// per transfer. Results pass the input register and then the result register.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder_unit
    import jsud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_done,
    output logic [3:0] status
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       item_end;
    logic       item_take;
    logic       load_ok;
    batch_t     batch;

    // input register
    jsud_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .text_end   (text_end),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_end   (item_end),
        .item_take  (item_take)
    );

    // decode step and state
    jsud_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_end   (item_end),
        .item_take  (item_take),
        .load_ok    (load_ok),
        .batch      (batch)
    );

    // result register
    jsud_out_buffer u_out_buffer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch       (batch),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_done (string_done),
        .status      (status)
    );

endmodule

[tb/sv/json_string_unescape_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_decoder_unit_test
// Self-checking bench for the streaming JSON string decoder.
// ----------------------------------------------------------------------------
// A driver presents text bytes and end-of-text marks from a queue. A short
// directed list comes first, then random string literals: mostly well-formed,
// with simple escapes, \u escapes and surrogate pairs, and some that are cut
// short or broken on purpose. Each accepted byte runs through a local decoder
// that queues the expected utf-8 bytes and end marks. The monitor compares
// every result transfer with the oldest expectation. Both sides idle at
// random between transfers.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder_unit_test;
    import jsud_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [7:0] value;
        logic       fin;
        bit         hold;
    } text_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       text_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [3:0] status;

    text_item_t text_q[$];
    result_t    pending_results[$];
    bit         hold_next = 1'b0;
    int         total_items = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         error_count = 0;
    int         quiet_cycles = 0;
    int         gap_left = 0;
    int         stall_left = 0;

    logic [7:0]  esc_letters [8] = '{8'h22, 8'h5C, "/", "b", "f", "n", "r", "t"};
    logic [15:0] bmp_corners [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                     16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

    // local copy of the decoder state
    phase_t      dec_phase = PH_IDLE;
    logic [15:0] hex_acc = 16'h0000;
    logic [2:0]  hex_count = 3'd0;
    logic        hex_bad = 1'b0;
    logic [9:0]  hi_half = 10'd0;

    json_string_unescape_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .text_end    (text_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_done (string_done),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // expected results
    // ------------------------------------------------------------------

    task automatic add_result(logic [7:0] b, logic v, logic d, logic [3:0] st);
        result_t r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.string_done = d;
        r.status      = st;
        pending_results.insert(pending_results.size(), r);
    endtask

    // closing quote, end of text or error: one final mark, back to idle
    task automatic end_string(logic [3:0] st);
        dec_phase = PH_IDLE;
        hex_acc   = '0;
        hex_count = '0;
        hex_bad   = 1'b0;
        hi_half   = '0;
        add_result(8'h00, 1'b0, 1'b1, st);
    endtask

    task automatic add_utf8(logic [20:0] cp);
        if (cp < UTF8_ONE_MAX)
        begin
            add_result(cp[7:0], 1'b1, 1'b0, ST_OK);
        end
        else if (cp < UTF8_TWO_MAX)
        begin
            add_result({3'b110, cp[10:6]}, 1'b1, 1'b0, ST_OK);
            add_result({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        end
        else if (cp < UTF8_THREE_MAX)
        begin
            add_result({4'b1110, cp[15:12]}, 1'b1, 1'b0, ST_OK);
            add_result({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_OK);
            add_result({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        end
        else
        begin
            add_result({5'b11110, cp[20:18]}, 1'b1, 1'b0, ST_OK);
            add_result({2'b10, cp[17:12]}, 1'b1, 1'b0, ST_OK);
            add_result({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_OK);
            add_result({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        end
    endtask

    // advance the local decoder by one accepted item
    task automatic decode_text_byte(logic [7:0] c, logic fin);
        logic [3:0]  nib;
        logic        is_hex;
        logic [15:0] cu;
        case (dec_phase)
            PH_BODY:
            begin
                if (fin)
                    end_string(ST_UNTERMINATED);
                else if (c == CH_QUOTE)
                    end_string(ST_OK);
                else if (c < CTRL_LIMIT)
                    end_string(ST_CONTROL_CHAR);
                else if (c == CH_BSLASH)
                    dec_phase = PH_ESC;
                else
                    add_result(c, 1'b1, 1'b0, ST_OK);
            end
            PH_ESC:
            begin
                if (fin)
                begin
                    end_string(ST_OPEN_ESCAPE);
                end
                else
                begin
                    dec_phase = PH_BODY;
                    case (c)
                        CH_QUOTE, CH_BSLASH, "/": add_result(c, 1'b1, 1'b0, ST_OK);
                        "b": add_result(8'h08, 1'b1, 1'b0, ST_OK);
                        "f": add_result(8'h0C, 1'b1, 1'b0, ST_OK);
                        "n": add_result(8'h0A, 1'b1, 1'b0, ST_OK);
                        "r": add_result(8'h0D, 1'b1, 1'b0, ST_OK);
                        "t": add_result(8'h09, 1'b1, 1'b0, ST_OK);
                        "u":
                        begin
                            dec_phase = PH_HEX_FIRST;
                            hex_acc   = '0;
                            hex_count = '0;
                            hex_bad   = 1'b0;
                        end
                        default: end_string(ST_BAD_ESCAPE);
                    endcase
                end
            end
            PH_HEX_FIRST, PH_HEX_LOW:
            begin
                if (fin)
                begin
                    end_string(ST_TRUNC_HEX);
                end
                else
                begin
                    is_hex = 1'b1;
                    nib    = 4'h0;
                    if (c >= "0" && c <= "9")
                        nib = 4'(c - "0");
                    else if (c >= "a" && c <= "f")
                        nib = 4'(c - "a" + 8'd10);
                    else if (c >= "A" && c <= "F")
                        nib = 4'(c - "A" + 8'd10);
                    else
                        is_hex = 1'b0;
                    hex_acc = {hex_acc[11:0], nib};
                    if (!is_hex)
                        hex_bad = 1'b1;
                    hex_count = hex_count + 3'd1;
                    if (hex_count >= 3'd4)
                    begin
                        if (hex_bad)
                        begin
                            end_string(ST_BAD_HEX);
                        end
                        else
                        begin
                            cu        = hex_acc;
                            hex_acc   = '0;
                            hex_count = '0;
                            hex_bad   = 1'b0;
                            if (dec_phase == PH_HEX_FIRST)
                            begin
                                if (cu >= SURR_HI_FIRST && cu <= SURR_HI_LAST)
                                begin
                                    hi_half   = cu[9:0];
                                    dec_phase = PH_WANT_BS;
                                end
                                else if (cu >= SURR_LO_FIRST && cu <= SURR_LO_LAST)
                                begin
                                    end_string(ST_UNPAIRED_LO);
                                end
                                else
                                begin
                                    dec_phase = PH_BODY;
                                    add_utf8({5'd0, cu});
                                end
                            end
                            else if (cu < SURR_LO_FIRST || cu > SURR_LO_LAST)
                            begin
                                end_string(ST_BAD_LOW);
                            end
                            else
                            begin
                                dec_phase = PH_BODY;
                                add_utf8(SUPP_BASE + {1'b0, hi_half, cu[9:0]});
                                hi_half = '0;
                            end
                        end
                    end
                end
            end
            PH_WANT_BS:
            begin
                if (fin || c != CH_BSLASH)
                    end_string(ST_UNPAIRED_HI);
                else
                    dec_phase = PH_WANT_U;
            end
            PH_WANT_U:
            begin
                if (fin || c != "u")
                begin
                    end_string(ST_UNPAIRED_HI);
                end
                else
                begin
                    dec_phase = PH_HEX_LOW;
                    hex_acc   = '0;
                    hex_count = '0;
                    hex_bad   = 1'b0;
                end
            end
            default:
            begin
                // idle: end of text is dropped, any byte opens a literal
                if (!fin)
                begin
                    dec_phase = PH_BODY;
                    hex_acc   = '0;
                    hex_count = '0;
                    hex_bad   = 1'b0;
                    hi_half   = '0;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    // idle cycles before the next transfer, with quiet stretches
    function automatic int draw_wait(int n);
        if ((n / 40) % 3 == 2)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    task automatic push_item(logic [7:0] b, logic fin);
        text_item_t it;
        it.value  = b;
        it.fin    = fin;
        it.hold   = hold_next;
        hold_next = 1'b0;
        text_q.insert(text_q.size(), it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] hex_digit(logic [3:0] n);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n - 4'd10);
    endfunction

    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        c = 8'($urandom);
        while (is_hex_char(c))
            c = 8'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] bad_escape_letter();
        logic [7:0] c;
        bit         known;
        do
        begin
            c     = 8'($urandom);
            known = (c == "u");
            for (int i = 0; i < 8; i++)
                if (c == esc_letters[i])
                    known = 1'b1;
        end
        while (known);
        return c;
    endfunction

    // text byte that passes through, corners now and then
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0: c = 8'h20;
            1: c = 8'h7F;
            2: c = 8'h80;
            3: c = 8'hFF;
            default: c = 8'($urandom_range(8'h20, 8'hFF));
        endcase
        if (c == CH_QUOTE || c == CH_BSLASH)
            c = 8'h41;
        return c;
    endfunction

    function automatic logic [9:0] pick_ten();
        case ($urandom_range(0, 5))
            0: return 10'h000;
            1: return 10'h3FF;
            default: return 10'($urandom);
        endcase
    endfunction

    // code unit outside the surrogate range
    function automatic logic [15:0] pick_bmp();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            3: return 16'($urandom_range(16'hE000, 16'hFFFF));
            default: return bmp_corners[$urandom_range(0, 7)];
        endcase
    endfunction

    task automatic push_hex(logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            push_item(hex_digit(v[i*4 +: 4]), 1'b0);
    endtask

    task automatic push_high_escape();
        push_text("\\u");
        push_hex({6'b110110, pick_ten()});
    endtask

    // a body element that ends the literal with an error
    task automatic push_broken();
        int          k;
        int          bad_at;
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: push_item(8'($urandom_range(0, 31)), 1'b0);
            1:
            begin
                push_item(CH_BSLASH, 1'b0);
                push_item(8'($urandom), 1'b1);
            end
            2:
            begin
                push_item(CH_BSLASH, 1'b0);
                push_item(bad_escape_letter(), 1'b0);
            end
            3:
            begin
                // cut short, maybe after a bad digit
                push_text("\\u");
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++)
                    push_item($urandom_range(0, 3) == 0 ? non_hex_byte()
                                                       : hex_digit(4'($urandom)), 1'b0);
                push_item(8'($urandom), 1'b1);
            end
            4:
            begin
                push_text("\\u");
                bad_at = $urandom_range(0, 3);
                for (int i = 0; i < 4; i++)
                    push_item(i == bad_at ? non_hex_byte() : hex_digit(4'($urandom)), 1'b0);
            end
            5:
            begin
                push_high_escape();
                if ($urandom_range(0, 2) == 0)
                    push_item(8'($urandom), 1'b1);
                else
                    push_item($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 8'h5B)),
                              1'b0);
            end
            6:
            begin
                push_high_escape();
                push_item(CH_BSLASH, 1'b0);
                if ($urandom_range(0, 2) == 0)
                    push_item(8'($urandom), 1'b1);
                else
                    push_item($urandom_range(0, 1) ? CH_BSLASH : 8'($urandom_range(0, 8'h74)),
                              1'b0);
            end
            7:
            begin
                push_high_escape();
                v = 16'($urandom);
                if (v[15:10] == 6'b110111)
                    v[13] = ~v[13];
                push_text("\\u");
                push_hex(v);
            end
            8:
            begin
                push_text("\\u");
                push_hex({6'b110111, pick_ten()});
            end
            default: push_item(8'($urandom), 1'b1);
        endcase
    endtask

    // one literal: opening byte, body elements, closing quote or cut
    task automatic push_random_string();
        int n_elems;
        int kind;
        bit broken;
        push_item($urandom_range(0, 7) == 0 ? 8'($urandom) : CH_QUOTE, 1'b0);
        n_elems = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
        broken  = 1'b0;
        for (int i = 0; i < n_elems && !broken; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                push_item(plain_byte(), 1'b0);
            end
            else if (kind < 58)
            begin
                push_item(CH_BSLASH, 1'b0);
                push_item(esc_letters[$urandom_range(0, 7)], 1'b0);
            end
            else if (kind < 75)
            begin
                push_text("\\u");
                push_hex(pick_bmp());
            end
            else if (kind < 88)
            begin
                push_high_escape();
                push_text("\\u");
                push_hex({6'b110111, pick_ten()});
            end
            else
            begin
                broken = 1'b1;
                push_broken();
            end
        end
        if (!broken)
            push_item($urandom_range(0, 6) == 0 ? 8'($urandom) : CH_QUOTE,
                      $urandom_range(0, 6) == 0);
    endtask

    // ------------------------------------------------------------------
    // driver: one transfer per item, random gaps, optional drain hold
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        text_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_text_byte(data_byte, text_end);
                items_sent++;
                gap_left = draw_wait(items_sent);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (text_q.size() != 0 &&
                         !(text_q[0].hold && pending_results.size() != 0))
                begin
                    nxt = text_q.pop_front();
                    data_byte <= nxt.value;
                    text_end  <= nxt.fin;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check each result transfer, random stalls
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: out_byte %0h status %0d",
                           out_byte, status);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
                    check_field("string_done", 8'(want.string_done), 8'(string_done));
                    check_field("status", 8'(want.status), 8'(status));
                end
                stall_left = draw_wait(results_seen);
                out_ready <= (stall_left == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= (stall_left == 0);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("json_string_unescape_decoder_unit_test: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        bit mid_hold;
        mid_hold = 1'b0;

        // end of text while idle is dropped
        push_item(8'h00, 1'b1);
        // passing corners and a simple escape, closed by a quote
        push_item(CH_QUOTE, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h20, 1'b0);
        push_text("\\t\"");
        // control char just under the limit
        push_item(CH_QUOTE, 1'b0);
        push_item(8'h1F, 1'b0);
        // end of text in the body
        push_item(CH_QUOTE, 1'b0);
        push_item(8'h00, 1'b1);
        // end of text right after a backslash
        push_text("\"\\");
        push_item(8'hFF, 1'b1);
        // unknown escape letter
        push_text("\"\\q");
        // cut short after a bad digit: truncation wins
        push_text("\"\\uZ");
        push_item(8'h00, 1'b1);
        // lone low surrogate
        push_text("\"\\uDFFF");

        // random literals, with a drain hold at the start and halfway
        hold_next = 1'b1;
        while (text_q.size() < 430)
        begin
            if ($urandom_range(0, 11) == 0)
                push_item(8'($urandom), 1'($urandom_range(0, 1)));
            else
                push_random_string();
            if (!mid_hold && text_q.size() >= 220)
            begin
                hold_next = 1'b1;
                mid_hold  = 1'b1;
            end
        end
        total_items = text_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (items_sent != total_items)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("json_string_unescape_decoder_unit_test: done, clean");
        else
            $display("json_string_unescape_decoder_unit_test: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/jsud_pkg.sv
rtl/jsud_in_stage.sv
rtl/jsud_decode.sv
rtl/jsud_out_buffer.sv
rtl/json_string_unescape_decoder_unit.sv
tb/sv/json_string_unescape_decoder_unit_test.sv
